// ===== design/swa_pkg.sv =====
// shared types and constants for the sliding window average block
// no dependencies; imported by every module of the block

package swa_pkg;

    // sample and result width, fixed by the stream format
    localparam int SAMPLE_W       = 16;
    // default number of samples in the averaging window
    localparam int WINDOW_DEFAULT = 16;

    // sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_START,
        ST_DIVIDE,
        ST_DONE
    } swa_state_t;

endpackage

// ===== design/swa_ring.sv =====
// sample ring memory, one write port and one read port, registered read
// uses swa_pkg for the sample width

module swa_ring #(
    parameter int WINDOW = swa_pkg::WINDOW_DEFAULT,
    parameter int PW     = $clog2(WINDOW)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [PW-1:0]               wr_addr,
    input  logic [swa_pkg::SAMPLE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [PW-1:0]               rd_addr,
    output logic [swa_pkg::SAMPLE_W-1:0] rd_data
);
    import swa_pkg::*;

    logic [SAMPLE_W-1:0] mem [WINDOW];
    logic [SAMPLE_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data valid in the cycle after the request
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/swa_div.sv =====
// serial restoring divider, one quotient bit per cycle, signed result fixup
// uses swa_pkg for the result width

module swa_div #(
    parameter int DVD_W = 20,
    parameter int DVS_W = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         negate,
    input  logic [DVD_W-1:0]             dividend,
    input  logic [DVS_W-1:0]             divisor,
    output logic                         busy,
    output logic [swa_pkg::SAMPLE_W-1:0] quotient
);
    import swa_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [DVS_W:0]   rem_shift;
    logic [DVS_W:0]   diff;
    logic             q_bit;
    logic [DVS_W-1:0] rem_next;
    logic [DVD_W-1:0] dvd_next;
    logic [SAMPLE_W-1:0] mag;

    // one restoring step: shift in the next dividend bit, trial subtract
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        q_bit     = ~diff[DVS_W];
        rem_next  = q_bit ? diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
        dvd_next  = {dvd_reg[DVD_W-2:0], q_bit};
    end

    // control: step counter and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CNT_W'(1));
        end
    end

    // datapath: dividend shifts out, quotient bits shift in behind it
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            neg_reg <= negate;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    // magnitude fits the result width, sign restored by two's complement
    assign mag      = dvd_reg[SAMPLE_W-1:0];
    assign quotient = neg_reg ? (~mag + 1'b1) : mag;
    assign busy     = busy_reg;

endmodule

// ===== design/sliding_window_average.sv =====
// top level of the sliding window average block: sequencer, running sum
// depends on swa_pkg, swa_ring (sample memory) and swa_div (serial divider)
//
//  channel | dir | tvalid/tready    | payload
//  --------+-----+------------------+-------------------------------------
//  s       | in  | s_tvalid/tready  | tdata[15:0] sample
//  m       | out | m_tvalid/tready  | tdata[15:0] average, tuser[0] window_full
//
// after a sample transfer the ring read and sum update come first, then the divider load,
// then the serial divider, one quotient bit per cycle until busy drops, then the output
// load; the divider works on a dividend of DVD_W = 16 + log2(WINDOW) bits
// the next sample is taken only after the output load, so one sample is in work at a time
// reset clears sum, fill count, write position and the output valid flag
// a result held by a stalled m side does not stop the next sample being taken;
// only the load of its own result waits for the output register to free up

module sliding_window_average #(
    parameter int WINDOW = swa_pkg::WINDOW_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [swa_pkg::SAMPLE_W-1:0] s_tdata,   // [15:0] sample
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [swa_pkg::SAMPLE_W-1:0] m_tdata,   // [15:0] average
    output logic [0:0]                   m_tuser    // [0] window_full
);
    import swa_pkg::*;

    localparam int PW = $clog2(WINDOW);
    localparam int FW = $clog2(WINDOW + 1);
    localparam int SW = SAMPLE_W + $clog2(WINDOW);

    swa_state_t state_reg, state_next;

    logic [SAMPLE_W-1:0] sample_reg;
    logic [SW-1:0]       sum_reg;
    logic [FW-1:0]       fill_reg;
    logic [PW-1:0]       pos_reg;

    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] avg_reg;
    logic                full_reg;

    logic                rd_en;
    logic                wr_en;
    logic                div_start;
    logic                load_out;
    logic [SAMPLE_W-1:0] old_sample;
    logic                div_busy;
    logic [SAMPLE_W-1:0] quotient;

    logic                warmup;
    logic [SW-1:0]       sample_ext;
    logic [SW-1:0]       old_ext;
    logic [SW-1:0]       sum_next;
    logic [SW-1:0]       sum_mag;

    // sample memory
    swa_ring #(
        .WINDOW (WINDOW),
        .PW     (PW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pos_reg),
        .wr_data (sample_reg),
        .rd_en   (rd_en),
        .rd_addr (pos_reg),
        .rd_data (old_sample)
    );

    // serial divider of the running sum by the sample count
    swa_div #(
        .DVD_W (SW),
        .DVS_W (FW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .negate   (sum_reg[SW-1]),
        .dividend (sum_mag),
        .divisor  (fill_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and sequencer strobes
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                wr_en      = 1'b1;
                state_next = ST_START;
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (!div_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // running sum update: add the new sample, drop the oldest once full
    always_comb
    begin
        warmup     = (fill_reg < FW'(WINDOW));
        sample_ext = {{(SW - SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
        old_ext    = {{(SW - SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample};
        sum_next   = warmup ? (sum_reg + sample_ext) : (sum_reg - old_ext + sample_ext);
        sum_mag    = sum_reg[SW-1] ? (~sum_reg + 1'b1) : sum_reg;
    end

    // sample capture on an input transfer
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            sample_reg <= s_tdata;
        end
    end

    // window state: sum, fill count and write position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            fill_reg <= '0;
            pos_reg  <= '0;
        end
        else if (wr_en)
        begin
            sum_reg <= sum_next;
            if (warmup)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            pos_reg <= (pos_reg == PW'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            avg_reg  <= quotient;
            full_reg <= (fill_reg == FW'(WINDOW));
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = avg_reg;
    assign m_tuser[0] = full_reg;

endmodule

// ===== design/swa_checker.sv =====
// port-level checks for the sliding window average block
// depends on swa_pkg; bound to sliding_window_average below

module swa_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [swa_pkg::SAMPLE_W-1:0] m_tdata,
    input logic [0:0]                   m_tuser
);
    import swa_pkg::*;

    logic full_seen_reg;

    // remembers a delivered result with the window already full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_seen_reg <= 1'b0;
        end
        else if (m_tvalid && m_tready && m_tuser[0])
        begin
            full_seen_reg <= 1'b1;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

    // one sample at a time: no transfer in the cycle after a transfer
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken twice in a row");

    // a fresh result needs work after its sample: none is offered right after the transfer
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid ##1 !m_tvalid)
        else $error("result appeared too early");

    // once the window is full it stays full
    a_full_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && full_seen_reg) |-> m_tuser[0])
        else $error("window_full dropped");

    // an offered result carries no unknown bits
    a_known_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !$isunknown({m_tdata, m_tuser}))
        else $error("unknown bits in result");

endmodule

bind sliding_window_average swa_checker u_swa_checker (.*);
